// ===== hw/rtl/epoch_milliseconds_to_date_macros.svh =====
// Assertion macros for the epoch milliseconds to date converter.
// Included by the top level; depends on nothing else.
`ifndef EPOCH_MILLISECONDS_TO_DATE_MACROS_SVH
`define EPOCH_MILLISECONDS_TO_DATE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define EMDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define EMDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/emdt_pkg.sv =====
// Shared types, constants and calendar tables for the date converter.
// No dependencies; used by emdt_year_ctr and epoch_milliseconds_to_date.
package emdt_pkg;

    localparam int CONST_W = 35;
    localparam int YEAR_W  = 16;

    typedef logic [CONST_W-1:0] ms_const_t;
    typedef logic [YEAR_W-1:0]  year_cnt_t;

    // Control from the sequencer to the year counter
    typedef struct packed {
        logic init;
        logic step;
    } year_ctl_t;

    // Calendar spans in milliseconds
    localparam ms_const_t MS_PER_SEC  = 35'd1000;
    localparam ms_const_t MS_PER_MIN  = 35'd60000;
    localparam ms_const_t MS_PER_HOUR = 35'd3600000;
    localparam ms_const_t MS_PER_DAY  = 35'd86400000;
    localparam ms_const_t MS_PER_D28  = 35'd2419200000;
    localparam ms_const_t MS_PER_D29  = 35'd2505600000;
    localparam ms_const_t MS_PER_D30  = 35'd2592000000;
    localparam ms_const_t MS_PER_D31  = 35'd2678400000;
    localparam ms_const_t MS_PER_Y365 = 35'd31536000000;
    localparam ms_const_t MS_PER_Y366 = 35'd31622400000;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    function automatic ms_const_t year_ms(input logic leap);
        return leap ? MS_PER_Y366 : MS_PER_Y365;
    endfunction

    function automatic ms_const_t month_ms(input logic [3:0] m, input logic leap);
        ms_const_t s;
        case (m) inside
            MONTH_FEB:                  s = leap ? MS_PER_D29 : MS_PER_D28;
            4'd4, 4'd6, 4'd9, 4'd11:    s = MS_PER_D30;
            default:                    s = MS_PER_D31;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/emdt_year_ctr.sv =====
// Year counter with Gregorian leap tracking for the date converter.
// Depends on emdt_pkg.
module emdt_year_ctr #(
    parameter int EPOCH_YEAR = 2000
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  emdt_pkg::year_ctl_t   ctl,
    output emdt_pkg::year_cnt_t   year,
    output logic                  leap
);

    localparam logic [6:0] INIT_C100 = 7'(EPOCH_YEAR % 100);
    localparam logic [1:0] INIT_C4   = 2'((EPOCH_YEAR / 100) % 4);

    emdt_pkg::year_cnt_t yr_reg, yr_next;
    logic [6:0] c100_reg, c100_next;
    logic [1:0] c4_reg, c4_next;

    always_comb
    begin
        yr_next   = yr_reg;
        c100_next = c100_reg;
        c4_next   = c4_reg;
        if (ctl.init)
        begin
            yr_next   = emdt_pkg::YEAR_W'(EPOCH_YEAR);
            c100_next = INIT_C100;
            c4_next   = INIT_C4;
        end
        else if (ctl.step)
        begin
            yr_next = yr_reg + 1'b1;
            if (c100_reg == 7'd99)
            begin
                c100_next = '0;
                c4_next   = c4_reg + 1'b1;
            end
            else
            begin
                c100_next = c100_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yr_reg   <= emdt_pkg::YEAR_W'(EPOCH_YEAR);
            c100_reg <= INIT_C100;
            c4_reg   <= INIT_C4;
        end
        else
        begin
            yr_reg   <= yr_next;
            c100_reg <= c100_next;
            c4_reg   <= c4_next;
        end
    end

    // Divisible by 4, except by 100, unless by 400
    assign leap = (yr_reg[1:0] == 2'd0) && ((c100_reg != 7'd0) || (c4_reg == 2'd0));
    assign year = yr_reg;

endmodule

// ===== hw/rtl/epoch_milliseconds_to_date.sv =====
// Top level of the epoch milliseconds to calendar date converter.
// Depends on emdt_pkg, emdt_year_ctr and epoch_milliseconds_to_date_macros.svh.
//
// Usage: software writes the boot time (milliseconds from the start of
// EPOCH_YEAR) through cfg_wr_en / cfg_wr_data while the block is idle.
// An input transaction (in_valid high, in_stall low) carries elapsed_ms;
// the block adds the boot time and returns one output transaction with
// year, month (1..12), day (from 0), hour, minute and second.
// One shared subtractor works on the millisecond sum under a small
// sequencer, removing one whole unit at a time in each stage:
// years, months, days, hours, minutes, then seconds; the leftover
// milliseconds are dropped. in_stall stays high from the accepting
// edge until the result is loaded, so a new transaction waits for it.
// The output register lets a new transaction in while a result waits;
// a held out_stall only delays loading the next result.
// Reset clears the boot time to zero and empties the output register.
`include "epoch_milliseconds_to_date_macros.svh"

module epoch_milliseconds_to_date #(
    parameter int EPOCH_YEAR = 2000,
    parameter int TIME_WIDTH = 42
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [TIME_WIDTH-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_WIDTH-1:0] elapsed_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [11:0]           year,
    output logic [3:0]            month,
    output logic [4:0]            day,
    output logic [4:0]            hour,
    output logic [5:0]            minute,
    output logic [5:0]            second
);

    localparam int SUM_W = TIME_WIDTH + 1;
    localparam int ALU_W = (SUM_W > emdt_pkg::CONST_W) ? SUM_W : emdt_pkg::CONST_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_YEAR  = 3'd1;
    localparam logic [2:0] S_MONTH = 3'd2;
    localparam logic [2:0] S_DAY   = 3'd3;
    localparam logic [2:0] S_HOUR  = 3'd4;
    localparam logic [2:0] S_MIN   = 3'd5;
    localparam logic [2:0] S_SEC   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [TIME_WIDTH-1:0] boot_reg, boot_next;
    logic                  out_valid_reg, out_valid_next;

    // Working value: milliseconds not yet assigned to a calendar unit
    logic [ALU_W-1:0]      num_reg, num_next;
    logic [3:0]            month_reg, month_next;
    logic [4:0]            day_reg, day_next;
    logic [4:0]            hour_reg, hour_next;
    logic [5:0]            min_reg, min_next;
    logic [5:0]            sec_reg, sec_next;

    logic [11:0]           out_year_reg, out_year_next;
    logic [3:0]            out_month_reg, out_month_next;
    logic [4:0]            out_day_reg, out_day_next;
    logic [4:0]            out_hour_reg, out_hour_next;
    logic [5:0]            out_min_reg, out_min_next;
    logic [5:0]            out_sec_reg, out_sec_next;

    // Shared subtractor
    logic [ALU_W-1:0]      alu_b;
    logic [ALU_W:0]        alu_diff;
    logic                  alu_ge;
    emdt_pkg::ms_const_t   alu_const;

    emdt_pkg::year_ctl_t   yr_ctl;
    emdt_pkg::year_cnt_t   yr_cnt;
    logic                  yr_leap;
    logic                  out_free;

    emdt_year_ctr #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_year (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (yr_ctl),
        .year  (yr_cnt),
        .leap  (yr_leap)
    );

    // Pick the span to subtract for the current step
    always_comb
    begin
        unique case (state_reg)
            S_YEAR:  alu_const = emdt_pkg::year_ms(yr_leap);
            S_MONTH: alu_const = emdt_pkg::month_ms(month_reg, yr_leap);
            S_DAY:   alu_const = emdt_pkg::MS_PER_DAY;
            S_HOUR:  alu_const = emdt_pkg::MS_PER_HOUR;
            S_MIN:   alu_const = emdt_pkg::MS_PER_MIN;
            S_SEC:   alu_const = emdt_pkg::MS_PER_SEC;
            default: alu_const = emdt_pkg::MS_PER_SEC;
        endcase
    end

    assign alu_b    = ALU_W'(alu_const);
    assign alu_diff = {1'b0, num_reg} - {1'b0, alu_b};
    assign alu_ge   = !alu_diff[ALU_W];

    // Output slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        out_valid_next = out_valid_reg;
        num_next       = num_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        min_next       = min_reg;
        sec_next       = sec_reg;
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_hour_next  = out_hour_reg;
        out_min_next   = out_min_reg;
        out_sec_next   = out_sec_reg;
        yr_ctl         = '0;

        if (cfg_wr_en)
        begin
            boot_next = cfg_wr_data;
        end

        // Drop the result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    num_next    = ALU_W'({1'b0, elapsed_ms}) + ALU_W'({1'b0, boot_reg});
                    month_next  = 4'd1;
                    day_next    = '0;
                    hour_next   = '0;
                    min_next    = '0;
                    sec_next    = '0;
                    yr_ctl.init = 1'b1;
                    state_next  = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (alu_ge)
                begin
                    num_next    = alu_diff[ALU_W-1:0];
                    yr_ctl.step = 1'b1;
                end
                else
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                // December takes whatever is left of the year
                if (alu_ge && (month_reg != emdt_pkg::MONTH_DEC))
                begin
                    num_next   = alu_diff[ALU_W-1:0];
                    month_next = month_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                if (alu_ge)
                begin
                    num_next = alu_diff[ALU_W-1:0];
                    day_next = day_reg + 1'b1;
                end
                else
                begin
                    state_next = S_HOUR;
                end
            end
            S_HOUR:
            begin
                if (alu_ge)
                begin
                    num_next  = alu_diff[ALU_W-1:0];
                    hour_next = hour_reg + 1'b1;
                end
                else
                begin
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                if (alu_ge)
                begin
                    num_next = alu_diff[ALU_W-1:0];
                    min_next = min_reg + 1'b1;
                end
                else
                begin
                    state_next = S_SEC;
                end
            end
            S_SEC:
            begin
                // Count whole seconds; the sub-second rest is dropped
                if (alu_ge)
                begin
                    num_next = alu_diff[ALU_W-1:0];
                    sec_next = sec_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register can take the result
                if (out_free)
                begin
                    out_year_next  = yr_cnt[11:0];
                    out_month_next = month_reg;
                    out_day_next   = day_reg;
                    out_hour_next  = hour_reg;
                    out_min_next   = min_reg;
                    out_sec_next   = sec_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            boot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        hour_reg      <= hour_next;
        min_reg       <= min_next;
        sec_reg       <= sec_next;
        out_year_reg  <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg   <= out_day_next;
        out_hour_reg  <= out_hour_next;
        out_min_reg   <= out_min_next;
        out_sec_reg   <= out_sec_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign year      = out_year_reg;
    assign month     = out_month_reg;
    assign day       = out_day_reg;
    assign hour      = out_hour_reg;
    assign minute    = out_min_reg;
    assign second    = out_sec_reg;

    `EMDT_ASSERT_NEXT(a_accept_starts_year, clk, rst_n, in_valid && !in_stall,
        state_reg == S_YEAR, "accepted transaction did not start the year count")
    `EMDT_ASSERT_NOW(a_sec_bound, clk, rst_n, state_reg == S_SEC,
        num_reg < ALU_W'(emdt_pkg::MS_PER_MIN), "milliseconds left exceed one minute")
    `EMDT_ASSERT_NOW(a_ms_left, clk, rst_n, state_reg == S_DONE,
        num_reg < ALU_W'(emdt_pkg::MS_PER_SEC), "milliseconds left exceed one second")
    `EMDT_ASSERT_NOW(a_out_ranges, clk, rst_n, out_valid_reg,
        out_month_reg >= 4'd1 && out_month_reg <= 4'd12 && out_day_reg <= 5'd30
            && out_hour_reg <= 5'd23 && out_min_reg <= 6'd59 && out_sec_reg <= 6'd59,
        "result field out of range")

endmodule

// ===== bench/epoch_milliseconds_to_date_chk.sv =====
`timescale 1ns / 1ps
// Scoreboard for the epoch milliseconds to date converter: snoops the
// config port and both channels, predicts each date and compares it.
// Depends on nothing but the block's port widths.
module epoch_milliseconds_to_date_chk #(
    parameter int EPOCH_YEAR = 2000,
    parameter int TIME_WIDTH = 42
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [TIME_WIDTH-1:0] cfg_wr_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [TIME_WIDTH-1:0] elapsed_ms,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [11:0]           year,
    input  logic [3:0]            month,
    input  logic [4:0]            day,
    input  logic [4:0]            hour,
    input  logic [5:0]            minute,
    input  logic [5:0]            second,
    output int                    err_count,
    output int                    open_count,
    output int                    checked_count,
    output int                    top_year
);

    localparam longint unsigned SECS_DAY = 86400;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_date_t;

    logic [TIME_WIDTH-1:0] boot_time;
    cal_date_t             expected_dates[$];

    function automatic bit leap_year(longint unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint unsigned days_in(int unsigned m, longint unsigned y);
        case (m)
            2:            return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // Strip whole years, then months, then split the rest into d/h/m/s
    function automatic cal_date_t calendar_of(logic [TIME_WIDTH:0] total_ms);
        longint unsigned secs;
        longint unsigned yr;
        int unsigned     mon;
        cal_date_t       d;
        secs = 64'(total_ms) / 64'd1000;
        yr   = EPOCH_YEAR;
        while (secs >= (leap_year(yr) ? 366 : 365) * SECS_DAY)
        begin
            secs -= (leap_year(yr) ? 366 : 365) * SECS_DAY;
            yr++;
        end
        mon = 1;
        while (mon < 12 && secs >= days_in(mon, yr) * SECS_DAY)
        begin
            secs -= days_in(mon, yr) * SECS_DAY;
            mon++;
        end
        d.year   = 12'(yr);
        d.month  = 4'(mon);
        d.day    = 5'(secs / SECS_DAY);
        secs     = secs % SECS_DAY;
        d.hour   = 5'(secs / 3600);
        secs     = secs % 3600;
        d.minute = 6'(secs / 60);
        d.second = 6'(secs % 60);
        return d;
    endfunction

    function automatic int field_miss(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int        errs;
        cal_date_t want;
        errs = 0;
        if (!rst_n)
        begin
            expected_dates.delete();
            boot_time     <= '0;
            err_count     <= 0;
            open_count    <= 0;
            checked_count <= 0;
            top_year      <= EPOCH_YEAR;
        end
        else
        begin
            if (cfg_wr_en)
                boot_time <= cfg_wr_data;
            if (in_valid && !in_stall)
                expected_dates.push_back(calendar_of({1'b0, elapsed_ms} + {1'b0, boot_time}));
            if (out_valid && !out_stall)
            begin
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: unexpected date %0d-%0d-%0d %0d:%0d:%0d, expected none",
                             $time, year, month, day, hour, minute, second);
                    errs++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    errs += field_miss("year", want.year, year);
                    errs += field_miss("month", want.month, month);
                    errs += field_miss("day", want.day, day);
                    errs += field_miss("hour", want.hour, hour);
                    errs += field_miss("minute", want.minute, minute);
                    errs += field_miss("second", want.second, second);
                    checked_count <= checked_count + 1;
                    if (int'(year) > top_year)
                        top_year <= int'(year);
                end
            end
            err_count  <= err_count + errs;
            open_count <= expected_dates.size();
        end
    end

endmodule

// ===== bench/epoch_milliseconds_to_date_tb.sv =====
`timescale 1ns / 1ps
// Top of the date converter bench: clock, reset, boot-time writes and
// elapsed-time stimulus. Depends on epoch_milliseconds_to_date (DUT) and
// epoch_milliseconds_to_date_chk, which does all prediction and checking.
module epoch_milliseconds_to_date_tb;

    localparam int EPOCH_YEAR = 2000;
    localparam int TIME_WIDTH = 42;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
    // Mean Gregorian year in milliseconds, only used to aim targets
    localparam longint unsigned MS_PER_MEAN_YEAR = 64'd31556952000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [TIME_WIDTH-1:0] cfg_wr_data = '0;
    logic                  in_valid    = 1'b0;
    logic [TIME_WIDTH-1:0] elapsed_ms  = '0;
    logic                  out_stall   = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [11:0]           year;
    logic [3:0]            month;
    logic [4:0]            day;
    logic [4:0]            hour;
    logic [5:0]            minute;
    logic [5:0]            second;

    // Random idling on both channels is enabled only while this is high
    logic idle_on    = 1'b0;
    int   stall_left = 0;
    int   boot_writes = 0;
    int   err_count;
    int   open_count;
    int   checked_count;
    int   top_year;

    always #10 clk = ~clk;

    epoch_milliseconds_to_date #(
        .EPOCH_YEAR (EPOCH_YEAR),
        .TIME_WIDTH (TIME_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .elapsed_ms  (elapsed_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second)
    );

    epoch_milliseconds_to_date_chk #(
        .EPOCH_YEAR (EPOCH_YEAR),
        .TIME_WIDTH (TIME_WIDTH)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .elapsed_ms    (elapsed_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .err_count     (err_count),
        .open_count    (open_count),
        .checked_count (checked_count),
        .top_year      (top_year)
    );

    // Output side back-pressure: stall bursts of random length, never back
    // to back. Once a burst starts it runs to
    // its end even if idling is switched off.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (idle_on && !out_stall && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic bit is_leap(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(int y, int m);
        case (m)
            2:            return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // Milliseconds from the start of the epoch year to a calendar instant;
    // day counts from zero, sod is the second of the day. Used to aim
    // stimulus at month, year and leap-day boundaries.
    function automatic longint unsigned ms_at(int y, int m, int d, int sod);
        longint unsigned days;
        days = 0;
        for (int i = EPOCH_YEAR; i < y; i++)
            days += is_leap(i) ? 366 : 365;
        for (int i = 1; i < m; i++)
            days += month_days(y, i);
        days += d;
        return (days * 86400 + sod) * 1000;
    endfunction

    function automatic logic [TIME_WIDTH-1:0] rnd_time();
        return TIME_WIDTH'({$urandom, $urandom});
    endfunction

    // Pick an elapsed time for the given boot time. Half the picks aim at
    // a chosen date, often near a boundary (last day of a month, midnight, last
    // second of a day), the rest are short uptimes or fully random.
    function automatic logic [TIME_WIDTH-1:0] pick_elapsed(logic [TIME_WIDTH-1:0] boot);
        logic [TIME_WIDTH:0] target;
        int                  sel;
        int                  boot_year;
        int                  y;
        int                  m;
        int                  d;
        int                  sod;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            boot_year = int'(64'(boot) / MS_PER_MEAN_YEAR);
            y = EPOCH_YEAR + boot_year
                + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 140) : $urandom_range(0, 20));
            if (y > EPOCH_YEAR + 270)
                y = EPOCH_YEAR + 270;
            m = $urandom_range(1, 12);
            d = $urandom_range(0, 1) ? month_days(y, m) - 1
                                     : $urandom_range(0, month_days(y, m) - 1);
            case ($urandom_range(0, 2))
                0:       sod = 0;
                1:       sod = 86399;
                default: sod = $urandom_range(0, 86399);
            endcase
            target = (TIME_WIDTH+1)'(ms_at(y, m, d, sod) + $urandom_range(0, 999));
            if (target >= boot && target - boot <= TIME_MAX)
                return TIME_WIDTH'(target - boot);
        end
        else if (sel < 8)
            return TIME_WIDTH'($urandom);
        return rnd_time();
    endfunction

    // Offer one transaction and hold it until accepted. Valid stays high
    // afterwards; a random gap lowers it first, in a separate time step.
    task automatic send(input logic [TIME_WIDTH-1:0] v);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        elapsed_ms <= v;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold off the input until every predicted date has been returned
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (open_count != 0);
    endtask

    // Boot time may only change while the converter is idle
    task automatic set_boot(input logic [TIME_WIDTH-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        boot_writes++;
    endtask

    initial
    begin
        logic [TIME_WIDTH-1:0] probes[$];
        logic [TIME_WIDTH-1:0] boot;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on <= 1'b1;

        // Directed: sub-second drop, minute rollover, month and year ends,
        // Feb 29 under the 400 rule, the 4 rule, and the 100 rule skipping
        // Feb 29 in 2100, plus the extreme and alternating bit patterns.
        set_boot('0);
        probes = '{TIME_WIDTH'(0), TIME_WIDTH'(999), TIME_WIDTH'(1000),
                   TIME_WIDTH'(59_999), TIME_WIDTH'(60_000)};
        probes.push_back(TIME_WIDTH'(ms_at(2000, 1, 30, 86399) + 999));
        probes.push_back(TIME_WIDTH'(ms_at(2000, 2, 0, 0)));
        probes.push_back(TIME_WIDTH'(ms_at(2000, 2, 28, 43200)));
        probes.push_back(TIME_WIDTH'(ms_at(2000, 12, 30, 86399) + 999));
        probes.push_back(TIME_WIDTH'(ms_at(2001, 1, 0, 0)));
        probes.push_back(TIME_WIDTH'(ms_at(2004, 2, 28, 0)));
        probes.push_back(TIME_WIDTH'(ms_at(2100, 2, 27, 86399) + 999));
        probes.push_back(TIME_WIDTH'(ms_at(2100, 3, 0, 0)));
        probes.push_back(TIME_WIDTH'(ms_at(2100, 12, 30, 3599)));
        probes.push_back(TIME_MAX);
        probes.push_back(42'h2AA_AAAA_AAAA);
        probes.push_back(42'h155_5555_5555);
        probes.push_back(42'h200_0000_0000);
        foreach (probes[i])
            send(probes[i]);

        // Largest boot time: the sum runs past the 42-bit range without wrap
        set_boot(TIME_MAX);
        send('0);
        send(TIME_WIDTH'(1));
        send(TIME_MAX);
        send(TIME_WIDTH'(ms_at(2200, 2, 27, 86399) + 999 - TIME_MAX));
        send(TIME_WIDTH'(ms_at(2200, 3, 0, 0) - TIME_MAX));

        // Random phases, each with its own boot time. Idling is re-drawn at random every
        // 40 transactions and is off for the tail of the last phase.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       boot = rnd_time();
                1:       boot = '0;
                2:       boot = TIME_WIDTH'(ms_at(EPOCH_YEAR + $urandom_range(1, 130), 1, 0, 0)
                                            - $urandom_range(1, 5000));
                3:       boot = TIME_MAX;
                4:       boot = TIME_WIDTH'($urandom);
                default: boot = rnd_time();
            endcase
            set_boot(boot);
            for (int k = 0; k < 240; k++)
            begin
                if (k % 40 == 0)
                    idle_on <= (ph == 5 && k >= 80) ? 1'b0 : ($urandom_range(0, 3) != 0);
                // Pause mid-phase until the pipeline is empty
                if (ph == 2 && k == 120)
                    drain();
                send(pick_elapsed(boot));
            end
        end

        drain();
        repeat (50) @(posedge clk);

        $display("Covered %0d conversions under %0d boot-time settings, years %0d to %0d.",
                 checked_count, boot_writes, EPOCH_YEAR, top_year);
        if (err_count == 0 && open_count == 0)
            $display("** epoch_milliseconds_to_date: PASSED **");
        else
            $display("** epoch_milliseconds_to_date: FAILED **");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial
    begin
        #60_000_000;
        $display("%0t: timeout with %0d dates outstanding", $time, open_count);
        $display("** epoch_milliseconds_to_date: FAILED **");
        $finish;
    end

endmodule
